[rtl/sbfp_pkg.sv]
// Shared constants and controller/datapath interface types for the servo bus
// frame parser. No dependencies; imported by every other module of the block.
package sbfp_pkg;

  // Frame store depth in bytes (one emitted frame is always this long)
  localparam int FRAME_BYTES = 64;
  localparam int BYTE_W      = 8;
  // Write position / fill count can hold FRAME_BYTES itself
  localparam int POS_W       = $clog2(FRAME_BYTES + 1);
  // Store address
  localparam int IDX_W       = $clog2(FRAME_BYTES);
  // Length arithmetic: length byte plus header overhead without overflow
  localparam int LEN_W       = BYTE_W + 2;
  localparam int HDR_BYTES   = 4;
  localparam int MIN_LEN     = 2;

  localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'hFF;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ID_MIN       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ID_MAX       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BROADCAST_ID = 2'd2;

  localparam logic [BYTE_W-1:0] ID_MIN_RST       = 8'd1;
  localparam logic [BYTE_W-1:0] ID_MAX_RST       = 8'd10;
  localparam logic [BYTE_W-1:0] BROADCAST_ID_RST = 8'd254;

  // Commands from controller to datapath
  typedef struct packed {
    logic start_frame;  // clear sum, position and count, store first header byte
    logic store;        // write input byte at the current position
    logic add_sum;      // accumulate input byte into the running sum
    logic load_params;  // load parameter count from the length byte
    logic dec_params;   // count one parameter byte
    logic emit_start;   // reset the readout address
    logic emit_step;    // read one store entry into the output register
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_header;    // input byte is 0xFF
    logic id_ok;        // input byte is an accepted device id
    logic len_ok;       // input byte is a usable length
    logic params_zero;  // no parameter bytes left
    logic params_one;   // exactly one parameter byte left
    logic sum_ok;       // input byte matches the inverted running sum
    logic emit_last;    // readout address is at the last store entry
    logic out_free;     // output register empty or being taken
  } dp_stat_t;

endpackage

[rtl/sbfp_datapath.sv]
// Datapath of the servo bus frame parser: config registers, frame store,
// running checksum, parameter count and the output register.
// Depends on sbfp_pkg.
module sbfp_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sbfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sbfp_pkg::BYTE_W-1:0]    cfg_data,
  input  logic [sbfp_pkg::BYTE_W-1:0]    rx_byte,
  input  sbfp_pkg::dp_cmd_t              cmd,
  output sbfp_pkg::dp_stat_t             stat,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sbfp_pkg::BYTE_W-1:0]    frame_byte,
  output logic                           frame_end
);
  import sbfp_pkg::*;

  logic [BYTE_W-1:0] id_min;
  logic [BYTE_W-1:0] id_max;
  logic [BYTE_W-1:0] broadcast_id;

  logic [BYTE_W-1:0] store_mem [FRAME_BYTES];
  logic [POS_W-1:0]  write_position;
  logic [POS_W-1:0]  params_left;
  logic [BYTE_W-1:0] running_sum;
  logic [IDX_W-1:0]  rd_idx;

  logic [BYTE_W-1:0] out_byte;
  logic              out_hit;
  logic              out_last;

  logic [LEN_W-1:0]  len_total;
  logic              pos_in_range;

  // Configuration writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      id_min       <= ID_MIN_RST;
      id_max       <= ID_MAX_RST;
      broadcast_id <= BROADCAST_ID_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ID_MIN:       id_min       <= cfg_data;
        CFG_ID_MAX:       id_max       <= cfg_data;
        CFG_BROADCAST_ID: broadcast_id <= cfg_data;
        default: ;
      endcase
    end
  end

  // Status decode of the incoming byte
  assign len_total    = LEN_W'(rx_byte) + LEN_W'(HDR_BYTES);
  assign pos_in_range = write_position < POS_W'(FRAME_BYTES);

  always_comb begin
    stat.is_header   = rx_byte == HEADER_BYTE;
    stat.id_ok       = (rx_byte >= id_min && rx_byte <= id_max) || rx_byte == broadcast_id;
    stat.len_ok      = rx_byte >= BYTE_W'(MIN_LEN) && len_total <= LEN_W'(FRAME_BYTES);
    stat.params_zero = params_left == '0;
    stat.params_one  = params_left == POS_W'(1);
    stat.sum_ok      = ~running_sum == rx_byte;
    stat.emit_last   = rd_idx == IDX_W'(FRAME_BYTES - 1);
    stat.out_free    = !out_valid || out_ready;
  end

  // Frame store: entries at or beyond the fill count read as zero, so no
  // clearing pass is needed between frames
  always_ff @(posedge clk) begin
    if (cmd.start_frame) begin
      store_mem[0] <= rx_byte;
    end else if (cmd.store && pos_in_range) begin
      store_mem[write_position[IDX_W-1:0]] <= rx_byte;
    end
    if (cmd.emit_step) begin
      out_byte <= store_mem[rd_idx];
    end
  end

  // Fill count, checksum and parameter count
  always_ff @(posedge clk) begin
    if (rst) begin
      write_position <= '0;
      running_sum    <= '0;
      params_left    <= '0;
    end else if (cmd.start_frame) begin
      write_position <= POS_W'(1);
      running_sum    <= '0;
      params_left    <= '0;
    end else begin
      if (cmd.store && pos_in_range) begin
        write_position <= write_position + POS_W'(1);
      end
      if (cmd.add_sum) begin
        running_sum <= running_sum + rx_byte;
      end
      if (cmd.load_params) begin
        params_left <= POS_W'(rx_byte - BYTE_W'(MIN_LEN));
      end else if (cmd.dec_params) begin
        params_left <= params_left - POS_W'(1);
      end
    end
  end

  // Readout address and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit_start) begin
        rd_idx <= '0;
      end else if (cmd.emit_step) begin
        rd_idx <= rd_idx + IDX_W'(1);
      end
      if (cmd.emit_step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_step) begin
      out_hit  <= POS_W'(rd_idx) < write_position;
      out_last <= stat.emit_last;
    end
  end

  assign frame_byte = out_hit ? out_byte : '0;
  assign frame_end  = out_last;

endmodule

[rtl/sbfp_ctrl.sv]
// Controller of the servo bus frame parser: parse phase state machine and
// frame readout sequencing. Depends on sbfp_pkg.
module sbfp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sbfp_pkg::dp_stat_t stat,
  output sbfp_pkg::dp_cmd_t  cmd
);
  import sbfp_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_HEAD2,
    PH_ID,
    PH_LEN,
    PH_CMD,
    PH_PARAM,
    PH_CHECK,
    PH_EMIT
  } phase_t;

  phase_t phase;
  phase_t phase_next;
  logic   accept;

  // Take bytes in every phase but readout
  assign in_ready = phase != PH_EMIT;
  assign accept   = in_valid && in_ready;

  // Next phase and datapath commands
  always_comb begin
    phase_next = phase;
    cmd        = '0;
    case (phase)
      PH_HEAD2: begin
        if (accept) begin
          if (stat.is_header) begin
            cmd.store  = 1'b1;
            phase_next = PH_ID;
          end else begin
            phase_next = PH_HUNT;
          end
        end
      end
      PH_ID: begin
        if (accept) begin
          if (stat.id_ok) begin
            cmd.store   = 1'b1;
            cmd.add_sum = 1'b1;
            phase_next  = PH_LEN;
          end else begin
            phase_next = PH_HUNT;
          end
        end
      end
      PH_LEN: begin
        if (accept) begin
          cmd.store   = 1'b1;
          cmd.add_sum = 1'b1;
          if (stat.len_ok) begin
            cmd.load_params = 1'b1;
            phase_next      = PH_CMD;
          end else begin
            phase_next = PH_HUNT;
          end
        end
      end
      PH_CMD: begin
        if (accept) begin
          cmd.store   = 1'b1;
          cmd.add_sum = 1'b1;
          phase_next  = stat.params_zero ? PH_CHECK : PH_PARAM;
        end
      end
      PH_PARAM: begin
        if (accept) begin
          cmd.store      = 1'b1;
          cmd.add_sum    = 1'b1;
          cmd.dec_params = 1'b1;
          if (stat.params_one) begin
            phase_next = PH_CHECK;
          end
        end
      end
      PH_CHECK: begin
        if (accept) begin
          cmd.store = 1'b1;
          if (stat.sum_ok) begin
            cmd.emit_start = 1'b1;
            phase_next     = PH_EMIT;
          end else begin
            phase_next = PH_HUNT;
          end
        end
      end
      PH_EMIT: begin
        // advance one store entry whenever the output register can take it
        if (stat.out_free) begin
          cmd.emit_step = 1'b1;
          if (stat.emit_last) begin
            phase_next = PH_HUNT;
          end
        end
      end
      default: begin
        // header hunt
        if (accept) begin
          if (stat.is_header) begin
            cmd.start_frame = 1'b1;
            phase_next      = PH_HEAD2;
          end else begin
            phase_next = PH_HUNT;
          end
        end
      end
    endcase
  end

  // Hold phase
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
    end else begin
      phase <= phase_next;
    end
  end

endmodule

[rtl/servo_bus_frame_parser.sv]
// Top level of the servo bus frame parser: joins the controller and datapath.
// Depends on sbfp_pkg, sbfp_ctrl and sbfp_datapath.
//
//   port group   direction  carries
//   s_axis_*     in         one received serial byte per item
//   m_axis_*     out        one frame byte per item, tlast on the 64th
//   cfg_*        in         writes of id_min, id_max, broadcast_id
//
// A received byte is taken whenever no readout is under way. After a frame with a
// good checksum the input stalls while the 64-entry frame store is read out, one
// byte per cycle through the output register while the receiver takes each byte.
// Reset is synchronous and restores the register defaults and header hunt;
// the frame store itself is never cleared (a fill count masks stale entries).
module servo_bus_frame_parser (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // [7:0] rx_byte
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,   // [7:0] frame_byte
  output logic                           m_axis_tlast,   // frame_end
  input  logic                           cfg_we,
  input  logic [sbfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);
  import sbfp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sbfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sbfp_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .rx_byte    (s_axis_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .frame_byte (m_axis_tdata),
    .frame_end  (m_axis_tlast)
  );

endmodule

[sim/servo_bus_frame_parser_tb.sv]
// Self-checking testbench for servo_bus_frame_parser: streams serial bytes in and
// checks every emitted frame byte against a frame parser model kept in this file.
// Depends on sbfp_pkg and the RTL of the block only.
module servo_bus_frame_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sbfp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // unmapped register index
  localparam int PHASES          = 5;
  localparam int PHASE_BYTES     = 80;
  localparam int LONG_HOLD       = 300;
  localparam int SETTLE_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT  = 2000;

  typedef enum logic [2:0] {
    P_HUNT, P_HEAD2, P_ID, P_LEN, P_CMD, P_PARAM, P_CHECK
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_item_t;

  typedef struct packed {
    logic [7:0] rx;
    logic       emits;  // this byte completes a good frame
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;    // [7:0] rx_byte
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;         // [7:0] frame_byte
  logic m_axis_tlast;               // frame_end
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  servo_bus_frame_parser dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Parser model state and id window
  parse_phase_t phase = P_HUNT;
  logic [7:0] frame_img [FRAME_BYTES];
  int         fill_pos = 0;
  logic [7:0] params_left = '0;
  logic [7:0] byte_sum = '0;
  logic [7:0] id_lo = ID_MIN_RST;
  logic [7:0] id_hi = ID_MAX_RST;
  logic [7:0] id_bcast = BROADCAST_ID_RST;

  frame_item_t frame_q [$];   // frame bytes still to come out
  logic        pin_q [$];     // hand-written outcome of each directed byte
  logic [7:0]  line_q [$];    // serial bytes of the current phase

  int   errors = 0;
  int   quiet_cycles = 0;
  int   emitted_n;
  logic pinned;
  logic idle_on = 1'b1;
  logic stall_long = 1'b0;
  frame_item_t want;

  directed_row_t directed_rows [26] = '{
    // second header byte not FF
    '{HEADER_BYTE, 1'b0}, '{8'h00, 1'b0},
    // id one above the window
    '{HEADER_BYTE, 1'b0}, '{HEADER_BYTE, 1'b0}, '{8'h0B, 1'b0},
    // broadcast id, length below 2
    '{HEADER_BYTE, 1'b0}, '{HEADER_BYTE, 1'b0}, '{8'hFE, 1'b0}, '{8'h01, 1'b0},
    // top of window, length overruns the store
    '{HEADER_BYTE, 1'b0}, '{HEADER_BYTE, 1'b0}, '{8'h0A, 1'b0}, '{8'h3D, 1'b0},
    // good frame, broadcast id, checksum FF
    '{HEADER_BYTE, 1'b0}, '{HEADER_BYTE, 1'b0}, '{8'hFE, 1'b0}, '{8'h03, 1'b0},
    '{8'h55, 1'b0}, '{8'hAA, 1'b0}, '{8'hFF, 1'b1},
    // bottom of window, bad checksum
    '{HEADER_BYTE, 1'b0}, '{HEADER_BYTE, 1'b0}, '{8'h01, 1'b0}, '{8'h02, 1'b0},
    '{8'h00, 1'b0}, '{8'h00, 1'b0}
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Append one byte to the frame image, dropping writes past its end
  function automatic void store_byte(input logic [7:0] b);
    if (fill_pos < FRAME_BYTES) begin
      frame_img[fill_pos] = b;
      fill_pos++;
    end
  endfunction

  // Advance the parser model by one serial byte; queue the frame if it completes
  function automatic int parse_byte(input logic [7:0] b);
    int emitted;
    emitted = 0;
    case (phase)
      P_HEAD2: begin
        if (b == HEADER_BYTE) begin
          store_byte(b);
          phase = P_ID;
        end else begin
          phase = P_HUNT;
        end
      end
      P_ID: begin
        if ((b >= id_lo && b <= id_hi) || b == id_bcast) begin
          store_byte(b);
          byte_sum = byte_sum + b;
          phase = P_LEN;
        end else begin
          phase = P_HUNT;
        end
      end
      P_LEN: begin
        store_byte(b);
        byte_sum = byte_sum + b;
        if (b < MIN_LEN || int'(b) + HDR_BYTES > FRAME_BYTES) begin
          phase = P_HUNT;
        end else begin
          params_left = 8'(b - MIN_LEN);
          phase = P_CMD;
        end
      end
      P_CMD: begin
        store_byte(b);
        byte_sum = byte_sum + b;
        phase = (params_left != 0) ? P_PARAM : P_CHECK;
      end
      P_PARAM: begin
        store_byte(b);
        byte_sum = byte_sum + b;
        params_left = 8'(params_left - 1);
        if (params_left == 0) phase = P_CHECK;
      end
      P_CHECK: begin
        store_byte(b);
        if (~byte_sum == b) begin
          for (int i = 0; i < FRAME_BYTES; i++)
            frame_q.push_back('{frame_img[i], i == FRAME_BYTES - 1});
          emitted = FRAME_BYTES;
        end
        phase = P_HUNT;
      end
      default: begin
        if (b == HEADER_BYTE) begin
          byte_sum = '0;
          fill_pos = 0;
          params_left = '0;
          for (int i = 0; i < FRAME_BYTES; i++) frame_img[i] = '0;
          store_byte(b);
          phase = P_HEAD2;
        end else begin
          phase = P_HUNT;
        end
      end
    endcase
    return emitted;
  endfunction

  // Offer one byte, with an occasional idle burst first; return once taken
  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Queue a frame with random content; mostly well formed, sometimes cut short
  task automatic queue_frame(input logic cut);
    logic [7:0] pkt [$];
    logic [7:0] id, len, csum, v;
    int roll, body, keep;
    roll = $urandom_range(0, 99);
    if (roll < 60) id = (id_lo <= id_hi) ? 8'($urandom_range(id_hi, id_lo)) : id_bcast;
    else if (roll < 80) id = id_bcast;
    else id = 8'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 75) len = 8'($urandom_range(2, 8));
    else if (roll < 85) len = 8'($urandom_range(9, FRAME_BYTES - HDR_BYTES));
    else if (roll < 90) len = 8'(FRAME_BYTES - HDR_BYTES);
    else if (roll < 95) len = 8'($urandom_range(0, MIN_LEN - 1));
    else len = 8'($urandom_range(FRAME_BYTES - HDR_BYTES + 1, 255));
    pkt.push_back(HEADER_BYTE);
    pkt.push_back(HEADER_BYTE);
    pkt.push_back(id);
    pkt.push_back(len);
    csum = id + len;
    body = (len >= MIN_LEN && int'(len) + HDR_BYTES <= FRAME_BYTES) ? int'(len) - 1 : 2;
    for (int i = 0; i < body; i++) begin
      v = 8'($urandom);
      csum = csum + v;
      pkt.push_back(v);
    end
    if (len >= MIN_LEN && int'(len) + HDR_BYTES <= FRAME_BYTES) begin
      v = ~csum;
      if ($urandom_range(0, 9) == 0) v = v ^ 8'($urandom_range(1, 255));
      pkt.push_back(v);
    end
    if (cut) begin
      keep = $urandom_range(1, pkt.size() - 1);
      while (pkt.size() > keep) void'(pkt.pop_back());
    end
    foreach (pkt[i]) line_q.push_back(pkt[i]);
  endtask

  // Build a phase worth of frames, noise and broken frames, then send it
  task automatic send_random(input int n_bytes);
    int roll;
    while (line_q.size() < n_bytes) begin
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        queue_frame(1'b0);
      end else if (roll < 88) begin
        repeat ($urandom_range(1, 4))
          line_q.push_back(($urandom_range(0, 2) == 0) ? HEADER_BYTE : 8'($urandom));
      end else begin
        queue_frame(1'b1);
      end
    end
    while (line_q.size() != 0) send_byte(line_q.pop_front());
    s_axis_tvalid <= 1'b0;
  endtask

  // Hold until every queued frame byte has come out, then let the block settle
  task automatic wait_drained();
    @(posedge clk);
    while (frame_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the id window, then a write to the unmapped index that must not land
  task automatic write_ids(input logic [7:0] lo, input logic [7:0] hi,
                           input logic [7:0] bc);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ID_MIN;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= CFG_ID_MAX;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_index <= CFG_BROADCAST_ID;
    cfg_data  <= bc;
    @(posedge clk);
    cfg_index <= CFG_SPARE;
    cfg_data  <= 8'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    id_lo = lo;
    id_hi = hi;
    id_bcast = bc;
  endtask

  // Predict on each accepted serial byte; check each accepted frame byte
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      emitted_n = parse_byte(s_axis_tdata);
      if (pin_q.size() != 0) begin
        pinned = pin_q.pop_front();
        if ((emitted_n != 0) != pinned) begin
          $display("%0t: rx %h frame out expected %0b actual %0b", $time, s_axis_tdata,
                   pinned, emitted_n != 0);
          errors++;
        end
      end
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (frame_q.size() == 0) begin
        $display("%0t: frame item expected none actual data %h last %b", $time,
                 m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        want = frame_q.pop_front();
        if (m_axis_tdata !== want.data || m_axis_tlast !== want.last) begin
          $display("%0t: frame item expected data %h last %b actual data %h last %b",
                   $time, want.data, want.last, m_axis_tdata, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run when no item moves for too long
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Frame receiver: random stalls, and one long hold-off on request
  initial begin
    forever begin
      if (stall_long) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        stall_long = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // Main sequence: reset, directed table, then random phases over several id windows
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      pin_q.push_back(directed_rows[i].emits);
      send_byte(directed_rows[i].rx);
    end
    stall_long = 1'b1;
    send_random(PHASE_BYTES);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      idle_on = (p != PHASES - 1);
      case (p)
        0: write_ids(8'h00, 8'hFF, 8'h80);
        1: write_ids(8'hC8, 8'h64, 8'hFF);
        2: write_ids(8'hFF, 8'hFF, 8'h00);
        default: write_ids(8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      send_random(PHASE_BYTES);
      wait_drained();
    end

    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

[servo_bus_frame_parser.f]
rtl/sbfp_pkg.sv
rtl/sbfp_datapath.sv
rtl/sbfp_ctrl.sv
rtl/servo_bus_frame_parser.sv
sim/servo_bus_frame_parser_tb.sv
